### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define KMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/kmd_pkg.sv
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int SCAN_ROWS = (ROWS < 8) ? ROWS : 8;
  localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [15:0] DEBOUNCE_RST = 16'd5000;

  typedef struct packed {
    logic [2:0]  column;
    logic [7:0]  row_levels;
    logic [31:0] time_us;
  } in_t;

  typedef struct packed {
    logic [2:0] key_row;
    logic [2:0] key_column;
    logic       key_level;
    logic       last_event;
  } out_t;

  typedef struct packed {
    logic [SCAN_ROWS-1:0] hit;
    logic [SCAN_ROWS-1:0] lvl;
    logic [2:0]           col;
  } scan_t;

endpackage

### src/key_matrix_debouncer_core.sv
`timescale 1ns / 1ps
// the first event of an item is offered in the cycle after the item is accepted
// throughput: one item per cycle while each item gives at most one event and the output is not stalled
// an item giving several events offers them one at a time on the single event port; the next item waits for its last
// rows are checked in parallel lanes, one per row, all in the accepting cycle
// reset clears key state at once (debounce_us back to 5000), no clearing pass

module key_matrix_debouncer_core
  import kmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_debounce_us
);

  logic [15:0]          debounce_r;
  logic [15:0]          debounce_nxt;
  logic                 in_acc;
  logic                 col_ok;
  logic                 lane_acc;
  logic [COL_AW-1:0]    col_idx;
  logic [SCAN_ROWS-1:0] lane_hit;
  scan_t                scan;

  assign cfg_ready    = 1'b1;
  assign debounce_nxt = (cfg_valid && cfg_ready) ? cfg_debounce_us : debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
    end else begin
      debounce_r <= debounce_nxt;
    end
  end

  assign in_acc   = in_valid && in_ready;
  assign col_ok   = {29'd0, in_data.column} < 32'(COLS);
  assign lane_acc = in_acc && col_ok;
  assign col_idx  = COL_AW'(in_data.column);

  for (genvar g = 0; g < SCAN_ROWS; g++) begin : g_lane
    kmd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (lane_acc),
      .col_idx  (col_idx),
      .level    (in_data.row_levels[g]),
      .now      (in_data.time_us),
      .debounce (debounce_r),
      .hit      (lane_hit[g])
    );
  end

  assign scan.hit = col_ok ? lane_hit : '0;
  assign scan.lvl = in_data.row_levels[SCAN_ROWS-1:0];
  assign scan.col = in_data.column;

  kmd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .scan      (scan),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### src/kmd_lane.sv
`timescale 1ns / 1ps

module kmd_lane
  import kmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [COL_AW-1:0] col_idx,
  input  logic              level,
  input  logic [31:0]       now,
  input  logic [15:0]       debounce,
  output logic              hit
);

  logic [COLS-1:0] raw_r;
  logic [COLS-1:0] raw_nxt;
  logic [COLS-1:0] stable_r;
  logic [COLS-1:0] stable_nxt;
  logic [COLS-1:0] ct_vld_r;
  logic [COLS-1:0] ct_vld_nxt;
  logic [31:0]     ct_r [COLS];
  logic [31:0]     ct_cur;
  logic [31:0]     elapsed;
  logic            changed;

  assign ct_cur  = ct_vld_r[col_idx] ? ct_r[col_idx] : 32'd0;
  assign elapsed = now - ct_cur;
  assign changed = raw_r[col_idx] != level;
  assign hit     = !changed && (elapsed > {16'd0, debounce}) && (stable_r[col_idx] != level);

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    ct_vld_nxt = ct_vld_r;
    if (accept) begin
      raw_nxt[col_idx] = level;
      if (changed) begin
        ct_vld_nxt[col_idx] = 1'b1;
      end
      if (hit) begin
        stable_nxt[col_idx] = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      stable_r <= '0;
      ct_vld_r <= '0;
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      ct_vld_r <= ct_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && changed) begin
      ct_r[col_idx] <= now;
    end
  end

endmodule

### src/kmd_merge.sv
`timescale 1ns / 1ps

module kmd_merge
  import kmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  scan_t scan,
  output logic  can_load,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  scan_t                pend_r;
  scan_t                pend_nxt;
  logic [SCAN_ROWS-1:0] low_bit;
  logic [2:0]           row_sel;
  logic                 lvl_sel;
  logic                 last;

  // lowest pending row
  always_comb begin
    row_sel = 3'd0;
    lvl_sel = 1'b0;
    for (int i = SCAN_ROWS - 1; i >= 0; i--) begin
      if (pend_r.hit[i]) begin
        row_sel = 3'(i);
        lvl_sel = pend_r.lvl[i];
      end
    end
  end

  assign low_bit   = pend_r.hit & (~pend_r.hit + SCAN_ROWS'(1));
  assign last      = (pend_r.hit & (pend_r.hit - SCAN_ROWS'(1))) == '0;
  assign out_valid = |pend_r.hit;
  assign can_load  = !out_valid || (out_ready && last);

  assign out_data.key_row    = row_sel;
  assign out_data.key_column = pend_r.col;
  assign out_data.key_level  = lvl_sel;
  assign out_data.last_event = last;

  always_comb begin
    pend_nxt = pend_r;
    if (out_valid && out_ready) begin
      pend_nxt.hit = pend_r.hit & ~low_bit;
    end
    if (load) begin
      pend_nxt = scan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r.hit <= '0;
    end else begin
      pend_r.hit <= pend_nxt.hit;
    end
    pend_r.lvl <= pend_nxt.lvl;
    pend_r.col <= pend_nxt.col;
  end

endmodule

### src/kmd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kmd_checker
  import kmd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic cfg_ready
);

  `KMD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled event changed")
  `KMD_ASSERT(a_idle_ready, clk, rst_n, !out_valid |-> in_ready, "input blocked with no event pending")
  `KMD_ASSERT(a_stall_no_take, clk, rst_n, out_valid && !out_ready |-> !in_ready, "item taken while event stalled")
  `KMD_ASSERT(a_cfg_ready, clk, rst_n, cfg_ready, "config port not ready")
  `KMD_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "event right after reset")

endmodule

bind key_matrix_debouncer_core kmd_checker u_kmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
